// ----- rtl/core/u2a_pkg.sv -----
// shared constants and types for the unsigned-to-ascii radix printer
// no dependencies; used by uint_to_ascii_radix_printer_top

package u2a_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIX_SELECT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PREFIX_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_DIGITS    = 2'd2;

   // radix codes
   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_DEC = 2'd2;
   localparam logic [1:0] RADIX_HEX = 2'd3;

   // ascii codes
   localparam int          CHAR_W       = 7;
   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_A_LOWER = 7'h61;
   localparam logic [6:0] CHAR_B_LOWER = 7'h62;
   localparam logic [6:0] CHAR_X_LOWER = 7'h78;

   localparam logic [3:0] DIGIT_NINE = 4'd9;
   localparam logic [3:0] DIGIT_TEN  = 4'd10;
   localparam logic [3:0] BCD_FIVE   = 4'd5;
   localparam logic [3:0] BCD_THREE  = 4'd3;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CONV   = 4'b0010,
      ST_PREFIX = 4'b0100,
      ST_DIGITS = 4'b1000
   } state_type;

endpackage

// ----- rtl/core/uint_to_ascii_radix_printer_top.sv -----
// top level of the unsigned-to-ascii radix printer: sequencer, shift-add-3 unit, digit scan
// depends on u2a_pkg
//
// busy covers the shift-add-3 loop (decimal only), the prefix characters (other radices only)
// and the digit scan: the shift-add-3 loop takes one bit a cycle, then every digit position is
// scanned from the top; a new request is taken in the cycle busy drops; a character leaves in
// the cycle after its prefix or scan cycle, leading zero positions outside the minimum width
// give none, and the receiver cannot stall
// reset (synchronous) returns to idle, drops the strobe and restores the register defaults

module uint_to_ascii_radix_printer_top #(
   parameter int VALUE_BITS = u2a_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [VALUE_BITS-1:0]            req_number,
   output logic                             rsp_valid,
   output logic [u2a_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                             rsp_last_char,
   input  logic                             csr_write_enable,
   input  logic [u2a_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [u2a_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int CNT_W      = $clog2(VALUE_BITS);
   localparam int DIG_W      = 4 * VALUE_BITS;
   // decimal digits needed for VALUE_BITS bits
   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W      = 4 * DEC_DIGITS;
   localparam int WCMP_W     = 7;

   u2a_pkg::state_type state_ff, state_in;

   logic [1:0]                  radix_ff, radix_in;
   logic                        prefix_ff, prefix_in;
   logic [u2a_pkg::CSR_DATA_W-1:0] min_digits_ff, min_digits_in;

   logic [VALUE_BITS-1:0]       val_ff, val_in;
   logic [BCD_W-1:0]            bcd_ff, bcd_in;
   logic [DIG_W-1:0]            dig_ff, dig_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        seen_ff, seen_in;
   logic                        second_ff, second_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [u2a_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [BCD_W-1:0]            bcd_adj;
   logic [BCD_W-1:0]            bcd_step;
   logic [DIG_W-1:0]            val_pad;
   logic [DIG_W-1:0]            bcd_pad;
   logic [VALUE_BITS-1:0]       load_val;
   logic [DIG_W-1:0]            dig_load;
   logic [3:0]                  top_digit;
   logic [u2a_pkg::CHAR_W-1:0]  digit_char;
   logic [WCMP_W-1:0]           eff_width;
   logic [WCMP_W-1:0]           cnt_ext;
   logic                        emit;

   // shift-add-3 step: correct each nibble, then shift in the next value bit
   always_comb begin
      for (int j = 0; j < DEC_DIGITS; j++) begin
         if (bcd_ff[4*j +: 4] >= u2a_pkg::BCD_FIVE) begin
            bcd_adj[4*j +: 4] = bcd_ff[4*j +: 4] + u2a_pkg::BCD_THREE;
         end else begin
            bcd_adj[4*j +: 4] = bcd_ff[4*j +: 4];
         end
      end
      bcd_step = {bcd_adj[BCD_W-2:0], val_ff[VALUE_BITS-1]};
   end

   // digit vector, one nibble per position, least significant position at the bottom
   assign load_val = (state_ff == u2a_pkg::ST_IDLE) ? req_number : val_ff;
   assign val_pad  = {{(DIG_W-VALUE_BITS){1'b0}}, load_val};
   assign bcd_pad  = {{(DIG_W-BCD_W){1'b0}}, bcd_step};

   always_comb begin
      for (int i = 0; i < VALUE_BITS; i++) begin
         case (radix_ff)
            u2a_pkg::RADIX_BIN: dig_load[4*i +: 4] = {3'b000, val_pad[i]};
            u2a_pkg::RADIX_OCT: dig_load[4*i +: 4] = {1'b0, val_pad[3*i +: 3]};
            u2a_pkg::RADIX_HEX: dig_load[4*i +: 4] = val_pad[4*i +: 4];
            default:            dig_load[4*i +: 4] = bcd_pad[4*i +: 4];
         endcase
      end
   end

   assign top_digit = dig_ff[DIG_W-1 -: 4];
   assign digit_char = (top_digit <= u2a_pkg::DIGIT_NINE) ?
                       (u2a_pkg::CHAR_ZERO + {3'b000, top_digit}) :
                       (u2a_pkg::CHAR_A_LOWER + {3'b000, top_digit - u2a_pkg::DIGIT_TEN});

   assign eff_width = ({1'b0, min_digits_ff} > WCMP_W'(VALUE_BITS)) ?
                      WCMP_W'(VALUE_BITS) : {1'b0, min_digits_ff};
   assign cnt_ext   = {{(WCMP_W-CNT_W){1'b0}}, cnt_ff};
   // leading zero positions are skipped unless inside the padding width or the units digit
   assign emit = seen_ff || (top_digit != 4'd0) || (cnt_ext < eff_width) || (cnt_ff == '0);

   always_comb begin
      state_in      = state_ff;
      radix_in      = radix_ff;
      prefix_in     = prefix_ff;
      min_digits_in = min_digits_ff;
      val_in        = val_ff;
      bcd_in        = bcd_ff;
      dig_in        = dig_ff;
      cnt_in        = cnt_ff;
      seen_in       = seen_ff;
      second_in     = second_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index)
            u2a_pkg::REG_RADIX_SELECT:  radix_in      = csr_write_data[1:0];
            u2a_pkg::REG_PREFIX_ENABLE: prefix_in     = csr_write_data[0];
            u2a_pkg::REG_MIN_DIGITS:    min_digits_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         u2a_pkg::ST_IDLE: begin
            if (start) begin
               val_in    = req_number;
               bcd_in    = '0;
               dig_in    = dig_load;
               cnt_in    = CNT_W'(VALUE_BITS - 1);
               seen_in   = 1'b0;
               second_in = 1'b0;
               if (radix_ff == u2a_pkg::RADIX_DEC) begin
                  state_in = u2a_pkg::ST_CONV;
               end else if (prefix_ff) begin
                  state_in = u2a_pkg::ST_PREFIX;
               end else begin
                  state_in = u2a_pkg::ST_DIGITS;
               end
            end
         end
         u2a_pkg::ST_CONV: begin
            bcd_in = bcd_step;
            val_in = {val_ff[VALUE_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               dig_in   = dig_load;
               cnt_in   = CNT_W'(VALUE_BITS - 1);
               state_in = u2a_pkg::ST_DIGITS;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         u2a_pkg::ST_PREFIX: begin
            rsp_valid_in = 1'b1;
            if (!second_ff) begin
               rsp_char_in = u2a_pkg::CHAR_ZERO;
               if (radix_ff == u2a_pkg::RADIX_OCT) begin
                  state_in = u2a_pkg::ST_DIGITS;
               end else begin
                  second_in = 1'b1;
               end
            end else begin
               rsp_char_in = (radix_ff == u2a_pkg::RADIX_BIN) ?
                             u2a_pkg::CHAR_B_LOWER : u2a_pkg::CHAR_X_LOWER;
               state_in    = u2a_pkg::ST_DIGITS;
            end
         end
         u2a_pkg::ST_DIGITS: begin
            rsp_valid_in = emit;
            rsp_char_in  = digit_char;
            rsp_last_in  = (cnt_ff == '0);
            seen_in      = seen_ff || emit;
            dig_in       = {dig_ff[DIG_W-5:0], 4'b0000};
            if (cnt_ff == '0) begin
               state_in = u2a_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = u2a_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= u2a_pkg::ST_IDLE;
         radix_ff      <= u2a_pkg::RADIX_DEC;
         prefix_ff     <= 1'b0;
         min_digits_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radix_ff      <= radix_in;
         prefix_ff     <= prefix_in;
         min_digits_ff <= min_digits_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      bcd_ff      <= bcd_in;
      dig_ff      <= dig_in;
      cnt_ff      <= cnt_in;
      seen_ff     <= seen_in;
      second_ff   <= second_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign busy          = (state_ff != u2a_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   // a character only ever follows a prefix or digit-scan cycle
   a_rsp_from_output_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == u2a_pkg::ST_PREFIX ||
                     $past(state_ff) == u2a_pkg::ST_DIGITS))
      else $error("character strobed without an output cycle");

   // the final character coincides with the return to idle
   a_last_ends_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> !busy)
      else $error("last character while still busy");

   a_last_has_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_char |-> rsp_valid)
      else $error("last flag without strobe");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // the bcd loop never produces characters
   a_conv_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == u2a_pkg::ST_CONV) |=> !rsp_valid)
      else $error("character during bcd conversion");

endmodule
